// File: rtl/smss_pkg.sv
// Shared constants, codes and control types for the sorted-matrix staircase search.
package smss_pkg;

  // Store geometry and data width
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int VALUE_WIDTH = 32;

  // Field and register widths fixed by the interface
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Derived sizes
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
  localparam int COL_CW    = $clog2(MAX_COLS + 1);

  // Register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Input actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;   // write the input beat into the store
    logic start;  // latch target and set cursors to the top-right corner
    logic step;   // advance one cell along the staircase
  } smss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range; // cursors still inside the region in use
    logic hit;      // entry under the cursors equals the target
  } smss_sts_t;

endpackage

// File: rtl/smss_ctrl.sv
// Controller: input/output handshake, walk sequencing and the result register.
module smss_ctrl import smss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_stall,
  output logic      out_valid,
  output logic      out_found,
  input  logic      out_stall,
  output smss_cmd_t cmd,
  input  smss_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_found_r, out_found_nxt;
  logic   in_acc;
  logic   finish;

  // A search needs a free result slot; loads only need an idle walker
  assign in_stall = (state_r != ST_IDLE) || ((in_action == ACT_SEARCH) && out_valid_r);
  assign in_acc   = in_valid && !in_stall;

  // Walk ends on a match or on leaving the region
  assign finish = (state_r == ST_WALK) && (!sts.in_range || sts.hit);

  always_comb begin
    cmd.load  = in_acc && (in_action == ACT_LOAD);
    cmd.start = in_acc && (in_action == ACT_SEARCH);
    cmd.step  = (state_r == ST_WALK) && sts.in_range && !sts.hit;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = sts.in_range && sts.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WALK))
    else $error("result beat raised without a walk");

  a_no_pending_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !out_valid_r)
    else $error("walk running while a result is still pending");

  a_start_enters_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_WALK))
    else $error("search start did not enter walk");

endmodule

// File: rtl/smss_dp.sv
// Datapath: matrix store, row/column cursors and the target compare.
module smss_dp import smss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smss_cmd_t              cmd,
  output smss_sts_t              sts,
  input  logic [IDX_W-1:0]       in_row_index,
  input  logic [IDX_W-1:0]       in_col_index,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [CFG_W-1:0]       rows_cfg,
  input  logic [CFG_W-1:0]       cols_cfg
);

  logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [VALUE_WIDTH-1:0] target_r;
  logic [ROW_CW-1:0]      row_r, row_nxt, rows_lim_r;
  logic [COL_CW-1:0]      col_r, col_nxt, col_dec;
  logic [ROW_CW-1:0]      rows_sat;
  logic [COL_CW-1:0]      cols_sat;
  logic [MEM_AW-1:0]      rd_addr, wr_addr;
  logic                   wr_ok;
  logic                   tgt_gt;

  // Registers above the store size saturate
  assign rows_sat = (32'(rows_cfg) > MAX_ROWS) ? ROW_CW'(MAX_ROWS) : ROW_CW'(rows_cfg);
  assign cols_sat = (32'(cols_cfg) > MAX_COLS) ? COL_CW'(MAX_COLS) : COL_CW'(cols_cfg);

  // Compare entry under the cursors against the target
  assign tgt_gt       = $signed(target_r) > $signed(rd_data_r);
  assign sts.hit      = (target_r == rd_data_r);
  assign sts.in_range = (row_r < rows_lim_r) && (col_r != '0);

  // Cursor update: down a row when the target is larger, else left a column
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.start) begin
      row_nxt = '0;
      col_nxt = cols_sat;
    end else if (cmd.step) begin
      if (tgt_gt) row_nxt = row_r + ROW_CW'(1);
      else        col_nxt = col_r - COL_CW'(1);
    end
  end

  // Read address follows the next cursors so data lines up with them
  assign col_dec = col_nxt - COL_CW'(1);
  assign rd_addr = MEM_AW'(32'(row_nxt) * MAX_COLS + 32'(col_dec));
  assign wr_addr = MEM_AW'(32'(in_row_index) * MAX_COLS + 32'(in_col_index));
  assign wr_ok   = (32'(in_row_index) < MAX_ROWS) && (32'(in_col_index) < MAX_COLS);

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) mem[wr_addr] <= in_value;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target_r   <= in_value;
      rows_lim_r <= rows_sat;
    end
  end

endmodule

// File: rtl/sorted_matrix_staircase_search.sv
// Top level: configuration registers, controller and datapath.
// Staircase search over a 64x64 store of signed 32-bit entries whose rows and
// columns ascend. A load beat (action 0) writes one entry and returns nothing.
// A search beat (action 1) returns one beat with found.
// The walk starts at the top-right corner of the region set by rows_in_use and
// cols_in_use and reads one store entry per cycle from a single registered read
// port, so the length of the staircase path sets when the result beat is valid.
// A new search is taken once the previous result has been delivered; loads are
// taken whenever no walk runs.
// Registers: rows_in_use at byte address 0, cols_in_use at 4, both 7 bits.
// The store has no reset; entries must be written before a search reads them.
module sorted_matrix_staircase_search import smss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [IDX_W-1:0]       in_row_index,
  input  logic [IDX_W-1:0]       in_col_index,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [CFG_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [CFG_W-1:0] cols_cfg_r, cols_cfg_nxt;
  logic             cfg_wr;
  logic             reg_sel;
  smss_cmd_t        cmd;
  smss_sts_t        sts;

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_ROWS: rows_cfg_nxt = pwdata[CFG_W-1:0];
        REG_COLS: cols_cfg_nxt = pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(1);
      cols_cfg_r <= CFG_W'(1);
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
    end
  end

  // Read-back
  always_comb begin
    case (reg_sel)
      REG_ROWS: prdata = DATA_W'(rows_cfg_r);
      REG_COLS: prdata = DATA_W'(cols_cfg_r);
      default:  prdata = '0;
    endcase
  end

  smss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_found (out_found),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  smss_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .rows_cfg     (rows_cfg_r),
    .cols_cfg     (cols_cfg_r)
  );

endmodule
